FILE: src/c8ic_pkg.sv
// Shared types, constants and decode helpers for the CHIP-8 instruction core.
// Used by c8ic_ctrl, c8ic_dp, chip8_instruction_core and c8ic_checker; depends on nothing.
`default_nettype none
package c8ic_pkg;

    // Sizes
    localparam int MEM_BYTES   = 4096;
    localparam int MEM_AW      = $clog2(MEM_BYTES);
    localparam int FB_ROWS     = 32;
    localparam int FB_RW       = $clog2(FB_ROWS);
    localparam int FB_WIDTH    = 64;
    localparam int FB_XW       = $clog2(FB_WIDTH);
    localparam int STACK_DEPTH = 16;
    localparam int STK_AW      = $clog2(STACK_DEPTH);
    localparam int SP_W        = $clog2(STACK_DEPTH + 1);
    localparam int FONT_BYTES  = 80;
    localparam int FONT_AW     = $clog2(FONT_BYTES);
    localparam int CFG_IW      = 2;
    localparam int CFG_DW      = 12;

    localparam logic [MEM_AW-1:0] RESET_PC = 12'd512;

    // Configuration register indexes
    localparam logic [CFG_IW-1:0] REG_PROGRAM_START = 2'd0;
    localparam logic [CFG_IW-1:0] REG_FONT_BASE     = 2'd1;

    // Request op codes
    localparam logic [1:0] OP_EXEC = 2'd0;
    localparam logic [1:0] OP_TICK = 2'd1;
    localparam logic [1:0] OP_LOAD = 2'd2;
    localparam logic [1:0] OP_ROW  = 2'd3;

    // Result status codes
    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_UNKNOWN = 2'd1;
    localparam logic [1:0] ST_STACK   = 2'd2;

    // Instruction classes; all but CL_SIMPLE need extra states after execute
    localparam logic [2:0] CL_SIMPLE = 3'd0;
    localparam logic [2:0] CL_FLAG   = 3'd1;
    localparam logic [2:0] CL_DRAW   = 3'd2;
    localparam logic [2:0] CL_BCD    = 3'd3;
    localparam logic [2:0] CL_STORE  = 3'd4;
    localparam logic [2:0] CL_LOAD   = 3'd5;

    localparam logic [7:0] FONT [FONT_BYTES] = '{
        8'hF0, 8'h90, 8'h90, 8'h90, 8'hF0, 8'h20, 8'h60, 8'h20, 8'h20, 8'h70,
        8'hF0, 8'h10, 8'hF0, 8'h80, 8'hF0, 8'hF0, 8'h10, 8'hF0, 8'h10, 8'hF0,
        8'h90, 8'h90, 8'hF0, 8'h10, 8'h10, 8'hF0, 8'h80, 8'hF0, 8'h10, 8'hF0,
        8'hF0, 8'h80, 8'hF0, 8'h90, 8'hF0, 8'hF0, 8'h10, 8'h20, 8'h40, 8'h40,
        8'hF0, 8'h90, 8'hF0, 8'h90, 8'hF0, 8'hF0, 8'h90, 8'hF0, 8'h10, 8'hF0,
        8'hF0, 8'h90, 8'hF0, 8'h90, 8'h90, 8'hE0, 8'h90, 8'hE0, 8'h90, 8'hE0,
        8'hF0, 8'h80, 8'h80, 8'h80, 8'hF0, 8'hE0, 8'h90, 8'h90, 8'h90, 8'hE0,
        8'hF0, 8'h80, 8'hF0, 8'h80, 8'hF0, 8'hF0, 8'h80, 8'hF0, 8'h80, 8'h80
    };

    // Controller to datapath commands
    typedef struct packed {
        logic clr_step;
        logic font_start;
        logic font_step;
        logic accept;
        logic fetch_hi;
        logic fetch_lo;
        logic latch_lo;
        logic rd_vy;
        logic rd_v0;
        logic exec;
        logic wr_flag;
        logic draw_rd;
        logic draw_wr;
        logic bcd_wr;
        logic st_rd;
        logic st_wr;
        logic ld_rd;
        logic ld_wr;
        logic tick;
        logic load;
        logic row_rd;
        logic out_load;
    } cmd_t;

    // Datapath to controller status
    typedef struct packed {
        logic [15:0] ins;
        logic        cnt_eq_x;
        logic        cnt_eq_n;
        logic        cnt_eq_2;
        logic        clr_last;
        logic        font_last;
        logic        font_pend;
    } sts_t;

    function automatic logic [2:0] ins_class(input logic [15:0] ins);
        logic [2:0] cl;
        cl = CL_SIMPLE;
        unique case (ins[15:12])
            4'h8:
                if (ins[3:0] == 4'h4 || ins[3:0] == 4'h5 || ins[3:0] == 4'h6 ||
                    ins[3:0] == 4'h7 || ins[3:0] == 4'hE)
                begin
                    cl = CL_FLAG;
                end
            4'hD: cl = CL_DRAW;
            4'hF:
                if (ins[7:0] == 8'h33)
                begin
                    cl = CL_BCD;
                end
                else if (ins[7:0] == 8'h55)
                begin
                    cl = CL_STORE;
                end
                else if (ins[7:0] == 8'h65)
                begin
                    cl = CL_LOAD;
                end
            default: cl = CL_SIMPLE;
        endcase
        return cl;
    endfunction

endpackage
`default_nettype wire

FILE: src/c8ic_ctrl.sv
// Sequencer of the CHIP-8 core: memory clear, font copy, fetch, execute, loops, result.
// Depends on c8ic_pkg; drives the c8ic_dp command struct.
`default_nettype none
module c8ic_ctrl (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           in_valid,
    output logic                in_stall,
    input  wire logic [1:0]     op,
    output logic                out_valid,
    input  wire logic           out_stall,
    input  wire c8ic_pkg::sts_t sts,
    output c8ic_pkg::cmd_t      cmd
);

    localparam logic [4:0] S_CLEAR = 5'd0;
    localparam logic [4:0] S_FONT  = 5'd1;
    localparam logic [4:0] S_IDLE  = 5'd2;
    localparam logic [4:0] S_F0    = 5'd3;
    localparam logic [4:0] S_F1    = 5'd4;
    localparam logic [4:0] S_F2    = 5'd5;
    localparam logic [4:0] S_VY    = 5'd6;
    localparam logic [4:0] S_V0    = 5'd7;
    localparam logic [4:0] S_EXEC  = 5'd8;
    localparam logic [4:0] S_FLAG  = 5'd9;
    localparam logic [4:0] S_DR0   = 5'd10;
    localparam logic [4:0] S_DR1   = 5'd11;
    localparam logic [4:0] S_BCD   = 5'd12;
    localparam logic [4:0] S_STR   = 5'd13;
    localparam logic [4:0] S_STW   = 5'd14;
    localparam logic [4:0] S_LDR   = 5'd15;
    localparam logic [4:0] S_LDW   = 5'd16;
    localparam logic [4:0] S_TICK  = 5'd17;
    localparam logic [4:0] S_LOAD  = 5'd18;
    localparam logic [4:0] S_ROW   = 5'd19;
    localparam logic [4:0] S_OUT   = 5'd20;

    logic [4:0] state_reg, state_next;
    logic       out_valid_reg, out_valid_next;
    logic       accept;
    logic       out_free;

    assign in_stall  = !(state_reg == S_IDLE && !sts.font_pend);
    assign accept    = in_valid && !in_stall;
    assign out_valid = out_valid_reg;
    assign out_free  = !out_valid_reg || !out_stall;

    // Next state and commands
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            S_CLEAR:
            begin
                cmd.clr_step = 1'b1;
                if (sts.clr_last)
                begin
                    state_next = S_IDLE;
                end
            end
            S_FONT:
            begin
                cmd.font_step = 1'b1;
                if (sts.font_last)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (sts.font_pend)
                begin
                    cmd.font_start = 1'b1;
                    state_next     = S_FONT;
                end
                else if (accept)
                begin
                    cmd.accept = 1'b1;
                    unique case (op)
                        c8ic_pkg::OP_EXEC: state_next = S_F0;
                        c8ic_pkg::OP_TICK: state_next = S_TICK;
                        c8ic_pkg::OP_LOAD: state_next = S_LOAD;
                        c8ic_pkg::OP_ROW:  state_next = S_ROW;
                        default:           state_next = S_ROW;
                    endcase
                end
            end
            S_F0:
            begin
                cmd.fetch_hi = 1'b1;
                state_next   = S_F1;
            end
            S_F1:
            begin
                cmd.fetch_lo = 1'b1;
                state_next   = S_F2;
            end
            S_F2:
            begin
                cmd.latch_lo = 1'b1;
                state_next   = S_VY;
            end
            S_VY:
            begin
                cmd.rd_vy  = 1'b1;
                state_next = S_V0;
            end
            S_V0:
            begin
                cmd.rd_v0  = 1'b1;
                state_next = S_EXEC;
            end
            S_EXEC:
            begin
                cmd.exec = 1'b1;
                unique case (c8ic_pkg::ins_class(sts.ins))
                    c8ic_pkg::CL_FLAG:  state_next = S_FLAG;
                    c8ic_pkg::CL_DRAW:  state_next = S_DR0;
                    c8ic_pkg::CL_BCD:   state_next = S_BCD;
                    c8ic_pkg::CL_STORE: state_next = S_STR;
                    c8ic_pkg::CL_LOAD:  state_next = S_LDR;
                    default:            state_next = S_ROW;
                endcase
            end
            S_FLAG:
            begin
                cmd.wr_flag = 1'b1;
                state_next  = S_ROW;
            end
            S_DR0:
            begin
                if (sts.cnt_eq_n)
                begin
                    state_next = S_FLAG;
                end
                else
                begin
                    cmd.draw_rd = 1'b1;
                    state_next  = S_DR1;
                end
            end
            S_DR1:
            begin
                cmd.draw_wr = 1'b1;
                state_next  = S_DR0;
            end
            S_BCD:
            begin
                cmd.bcd_wr = 1'b1;
                if (sts.cnt_eq_2)
                begin
                    state_next = S_ROW;
                end
            end
            S_STR:
            begin
                cmd.st_rd  = 1'b1;
                state_next = S_STW;
            end
            S_STW:
            begin
                cmd.st_wr  = 1'b1;
                state_next = sts.cnt_eq_x ? S_ROW : S_STR;
            end
            S_LDR:
            begin
                cmd.ld_rd  = 1'b1;
                state_next = S_LDW;
            end
            S_LDW:
            begin
                cmd.ld_wr  = 1'b1;
                state_next = sts.cnt_eq_x ? S_ROW : S_LDR;
            end
            S_TICK:
            begin
                cmd.tick   = 1'b1;
                state_next = S_ROW;
            end
            S_LOAD:
            begin
                cmd.load   = 1'b1;
                state_next = S_ROW;
            end
            S_ROW:
            begin
                cmd.row_rd = 1'b1;
                state_next = S_OUT;
            end
            S_OUT:
            begin
                if (out_free)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    // Hold the result until taken
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end
        if (cmd.out_load)
        begin
            out_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule
`default_nettype wire

FILE: src/c8ic_dp.sv
// Datapath of the CHIP-8 core: memory, V registers, frame buffer, stack, timers, result.
// Depends on c8ic_pkg; steered by c8ic_ctrl through the command struct.
`default_nettype none
module c8ic_dp (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire c8ic_pkg::cmd_t                   cmd,
    output c8ic_pkg::sts_t                        sts,
    input  wire logic                             cfg_we,
    input  wire logic [c8ic_pkg::CFG_IW-1:0]      cfg_index,
    input  wire logic [c8ic_pkg::CFG_DW-1:0]      cfg_data,
    input  wire logic [11:0]                      load_address,
    input  wire logic [7:0]                       load_data,
    input  wire logic [15:0]                      keys,
    input  wire logic [7:0]                       random_byte,
    input  wire logic [4:0]                       row_select,
    output logic [11:0]                           program_counter,
    output logic [15:0]                           index_value,
    output logic [7:0]                            delay_value,
    output logic                                  sound_on,
    output logic                                  waiting_key,
    output logic [63:0]                           display_row,
    output logic [1:0]                            status
);

    localparam int AW = c8ic_pkg::MEM_AW;

    // Storage
    logic [7:0]                    mem [c8ic_pkg::MEM_BYTES];
    logic [7:0]                    vmem [16];
    logic [c8ic_pkg::FB_WIDTH-1:0] fbmem [c8ic_pkg::FB_ROWS];
    logic [AW-1:0]                 stack_reg [c8ic_pkg::STACK_DEPTH];

    // Control state
    logic [AW-1:0]                pc_reg, pc_next;
    logic [15:0]                  i_reg, i_next;
    logic [7:0]                   dt_reg, dt_next;
    logic [7:0]                   st_reg, st_next;
    logic [c8ic_pkg::SP_W-1:0]    sp_reg, sp_next;
    logic [15:0]                  v_valid_reg;
    logic [c8ic_pkg::FB_ROWS-1:0] fb_valid_reg;
    logic [AW-1:0]                clr_addr_reg;
    logic [c8ic_pkg::FONT_AW-1:0] font_cnt_reg;
    logic                         font_pend_reg;
    logic [AW-1:0]                font_base_reg;
    logic [AW-1:0]                copy_base_reg;
    logic [1:0]                   status_reg, status_next;
    logic                         wait_reg, wait_next;
    logic [3:0]                   cnt_reg;

    // Payload
    logic [15:0]                   ins_reg;
    logic [7:0]                    vx_reg, vy_reg;
    logic                          flag_reg, flag_next;
    logic [15:0]                   keys_reg;
    logic [7:0]                    rnd_reg;
    logic [4:0]                    row_sel_reg;
    logic [AW-1:0]                 ld_addr_reg;
    logic [7:0]                    ld_data_reg;
    logic [7:0]                    mem_q_reg;
    logic [7:0]                    vq_raw_reg;
    logic                          vq_vld_reg;
    logic [c8ic_pkg::FB_WIDTH-1:0] fb_q_raw_reg;
    logic                          fbq_vld_reg;

    // Decoded fields and helpers
    logic [3:0]                    x, y, n;
    logic [7:0]                    kk;
    logic [AW-1:0]                 nnn;
    logic [7:0]                    vq;
    logic [c8ic_pkg::FB_WIDTH-1:0] fb_q;
    logic [AW-1:0]                 pc_inc, pc_skip;
    logic [AW-1:0]                 i_cnt;
    logic [c8ic_pkg::STK_AW-1:0]   top_idx;
    logic [c8ic_pkg::FB_RW-1:0]    draw_row;
    logic [c8ic_pkg::FB_WIDTH-1:0] sprite_mask;
    logic [c8ic_pkg::FB_WIDTH-1:0] sprite_base;
    logic [3:0]                    high_key;
    logic [1:0]                    bcd_h;
    logic [6:0]                    bcd_r;
    logic [14:0]                   bcd_prod;
    logic [3:0]                    bcd_t, bcd_o;
    logic [7:0]                    bcd_digit;
    logic                          key_hit;
    logic [8:0]                    alu_sum;

    // Execute outputs
    logic       push_en;
    logic       fb_clear;
    logic       ve_we;
    logic [7:0] ve_data;

    // Memory ports
    logic          mem_we;
    logic [AW-1:0] mem_waddr;
    logic [7:0]    mem_wdata;
    logic          mem_re;
    logic [AW-1:0] mem_raddr;

    logic       v_we;
    logic [3:0] v_waddr;
    logic [7:0] v_wdata;
    logic       v_re;
    logic [3:0] v_raddr;

    logic                       fb_re;
    logic [c8ic_pkg::FB_RW-1:0] fb_raddr;

    assign x    = ins_reg[11:8];
    assign y    = ins_reg[7:4];
    assign n    = ins_reg[3:0];
    assign kk   = ins_reg[7:0];
    assign nnn  = ins_reg[11:0];
    assign vq   = vq_vld_reg ? vq_raw_reg : 8'd0;
    assign fb_q = fbq_vld_reg ? fb_q_raw_reg : '0;

    assign pc_inc   = pc_reg + AW'(2);
    assign pc_skip  = pc_reg + AW'(4);
    assign i_cnt    = i_reg[AW-1:0] + AW'(cnt_reg);
    assign top_idx  = c8ic_pkg::STK_AW'(sp_reg - c8ic_pkg::SP_W'(1));
    assign draw_row = vy_reg[c8ic_pkg::FB_RW-1:0] + c8ic_pkg::FB_RW'(cnt_reg);
    assign key_hit  = (vx_reg < 8'd16) && keys_reg[vx_reg[3:0]];
    assign alu_sum  = {1'b0, vx_reg} + {1'b0, vy_reg};

    // Place the sprite byte at the left edge, then rotate right by the x start
    assign sprite_base = {mem_q_reg, {(c8ic_pkg::FB_WIDTH-8){1'b0}}};
    assign sprite_mask = c8ic_pkg::FB_WIDTH'({sprite_base, sprite_base}
                                             >> vx_reg[c8ic_pkg::FB_XW-1:0]);

    // Pick the highest pressed key
    always_comb
    begin
        high_key = 4'd0;
        for (int k = 0; k < 16; k++)
        begin
            if (keys_reg[k])
            begin
                high_key = 4'(k);
            end
        end
    end

    // Split Vx into decimal digits
    always_comb
    begin
        if (vx_reg >= 8'd200)
        begin
            bcd_h = 2'd2;
        end
        else if (vx_reg >= 8'd100)
        begin
            bcd_h = 2'd1;
        end
        else
        begin
            bcd_h = 2'd0;
        end
        bcd_r    = 7'(vx_reg - 8'(bcd_h) * 8'd100);
        bcd_prod = 15'(bcd_r) * 15'd205;
        bcd_t    = bcd_prod[14:11];
        bcd_o    = 4'(bcd_r - 7'(bcd_t) * 7'd10);
        unique case (cnt_reg[1:0])
            2'd0:    bcd_digit = 8'(bcd_h);
            2'd1:    bcd_digit = 8'(bcd_t);
            default: bcd_digit = 8'(bcd_o);
        endcase
    end

    // Execute one instruction; also clear status on accept, count the timers down on tick and set the draw flag
    always_comb
    begin
        pc_next     = pc_reg;
        i_next      = i_reg;
        dt_next     = dt_reg;
        st_next     = st_reg;
        sp_next     = sp_reg;
        status_next = status_reg;
        wait_next   = wait_reg;
        flag_next   = flag_reg;
        push_en     = 1'b0;
        fb_clear    = 1'b0;
        ve_we       = 1'b0;
        ve_data     = 8'd0;
        if (cmd.accept)
        begin
            status_next = c8ic_pkg::ST_OK;
            wait_next   = 1'b0;
        end
        if (cmd.tick)
        begin
            if (dt_reg != 8'd0)
            begin
                dt_next = dt_reg - 8'd1;
            end
            if (st_reg != 8'd0)
            begin
                st_next = st_reg - 8'd1;
            end
        end
        if (cmd.draw_wr && ((fb_q & sprite_mask) != '0))
        begin
            flag_next = 1'b1;
        end
        if (cmd.exec)
        begin
            pc_next = pc_inc;
            unique case (ins_reg[15:12])
                4'h0:
                    if (ins_reg == 16'h00E0)
                    begin
                        fb_clear = 1'b1;
                    end
                    else if (ins_reg == 16'h00EE)
                    begin
                        if (sp_reg == '0)
                        begin
                            status_next = c8ic_pkg::ST_STACK;
                        end
                        else
                        begin
                            sp_next = sp_reg - c8ic_pkg::SP_W'(1);
                            pc_next = stack_reg[top_idx];
                        end
                    end
                4'h1: pc_next = nnn;
                4'h2:
                    if (sp_reg >= c8ic_pkg::SP_W'(c8ic_pkg::STACK_DEPTH))
                    begin
                        status_next = c8ic_pkg::ST_STACK;
                    end
                    else
                    begin
                        push_en = 1'b1;
                        sp_next = sp_reg + c8ic_pkg::SP_W'(1);
                        pc_next = nnn;
                    end
                4'h3: if (vx_reg == kk) pc_next = pc_skip;
                4'h4: if (vx_reg != kk) pc_next = pc_skip;
                4'h5: if (vx_reg == vy_reg) pc_next = pc_skip;
                4'h6:
                begin
                    ve_we   = 1'b1;
                    ve_data = kk;
                end
                4'h7:
                begin
                    ve_we   = 1'b1;
                    ve_data = vx_reg + kk;
                end
                4'h8:
                    unique case (n)
                        4'h0: begin ve_we = 1'b1; ve_data = vy_reg; end
                        4'h1: begin ve_we = 1'b1; ve_data = vx_reg | vy_reg; end
                        4'h2: begin ve_we = 1'b1; ve_data = vx_reg & vy_reg; end
                        4'h3: begin ve_we = 1'b1; ve_data = vx_reg ^ vy_reg; end
                        4'h4:
                        begin
                            ve_we     = 1'b1;
                            ve_data   = alu_sum[7:0];
                            flag_next = alu_sum[8];
                        end
                        4'h5:
                        begin
                            ve_we     = 1'b1;
                            ve_data   = vx_reg - vy_reg;
                            flag_next = vx_reg >= vy_reg;
                        end
                        4'h6:
                        begin
                            ve_we     = 1'b1;
                            ve_data   = {1'b0, vx_reg[7:1]};
                            flag_next = vx_reg[0];
                        end
                        4'h7:
                        begin
                            ve_we     = 1'b1;
                            ve_data   = vy_reg - vx_reg;
                            flag_next = vy_reg >= vx_reg;
                        end
                        4'hE:
                        begin
                            ve_we     = 1'b1;
                            ve_data   = {vx_reg[6:0], 1'b0};
                            flag_next = vx_reg[7];
                        end
                        default: status_next = c8ic_pkg::ST_UNKNOWN;
                    endcase
                4'h9: if (vx_reg != vy_reg) pc_next = pc_skip;
                4'hA: i_next = {4'd0, nnn};
                4'hB: pc_next = nnn + AW'(vq);
                4'hC:
                begin
                    ve_we   = 1'b1;
                    ve_data = rnd_reg & kk;
                end
                4'hD: flag_next = 1'b0;
                4'hE:
                    if (kk == 8'h9E)
                    begin
                        if (key_hit) pc_next = pc_skip;
                    end
                    else if (kk == 8'hA1)
                    begin
                        if (!key_hit) pc_next = pc_skip;
                    end
                    else
                    begin
                        status_next = c8ic_pkg::ST_UNKNOWN;
                    end
                default:
                    unique case (kk)
                        8'h07: begin ve_we = 1'b1; ve_data = dt_reg; end
                        8'h0A:
                            if (keys_reg == 16'd0)
                            begin
                                pc_next   = pc_reg;
                                wait_next = 1'b1;
                            end
                            else
                            begin
                                ve_we   = 1'b1;
                                ve_data = 8'(high_key);
                            end
                        8'h15: dt_next = vx_reg;
                        8'h18: st_next = vx_reg;
                        8'h1E: i_next = i_reg + 16'(vx_reg);
                        8'h29: i_next = 16'({vx_reg, 2'b00}) + 16'(vx_reg)
                                        + 16'(font_base_reg);
                        8'h33, 8'h55, 8'h65: i_next = i_reg;
                        default: status_next = c8ic_pkg::ST_UNKNOWN;
                    endcase
            endcase
        end
        // Load the start address on a program_start write
        if (cfg_we && cfg_index == c8ic_pkg::REG_PROGRAM_START)
        begin
            pc_next = cfg_data;
        end
    end

    // Select the memory ports
    always_comb
    begin
        mem_we    = 1'b0;
        mem_waddr = clr_addr_reg;
        mem_wdata = 8'd0;
        priority if (cmd.clr_step)
        begin
            mem_we = 1'b1;
            if (clr_addr_reg < AW'(c8ic_pkg::FONT_BYTES))
            begin
                mem_wdata = c8ic_pkg::FONT[clr_addr_reg[c8ic_pkg::FONT_AW-1:0]];
            end
        end
        else if (cmd.font_step)
        begin
            mem_we    = 1'b1;
            mem_waddr = copy_base_reg + AW'(font_cnt_reg);
            mem_wdata = c8ic_pkg::FONT[font_cnt_reg];
        end
        else if (cmd.load)
        begin
            mem_we    = 1'b1;
            mem_waddr = ld_addr_reg;
            mem_wdata = ld_data_reg;
        end
        else if (cmd.bcd_wr)
        begin
            mem_we    = 1'b1;
            mem_waddr = i_cnt;
            mem_wdata = bcd_digit;
        end
        else if (cmd.st_wr)
        begin
            mem_we    = 1'b1;
            mem_waddr = i_cnt;
            mem_wdata = vq;
        end
        else
        begin
            mem_we = 1'b0;
        end

        mem_re = cmd.fetch_hi || cmd.fetch_lo || cmd.draw_rd || cmd.ld_rd;
        priority if (cmd.fetch_hi)
        begin
            mem_raddr = pc_reg;
        end
        else if (cmd.fetch_lo)
        begin
            mem_raddr = pc_reg + AW'(1);
        end
        else
        begin
            mem_raddr = i_cnt;
        end

        v_we = ve_we || cmd.wr_flag || cmd.ld_wr;
        priority if (cmd.wr_flag)
        begin
            v_waddr = 4'hF;
            v_wdata = {7'd0, flag_reg};
        end
        else if (cmd.ld_wr)
        begin
            v_waddr = cnt_reg;
            v_wdata = mem_q_reg;
        end
        else
        begin
            v_waddr = x;
            v_wdata = ve_data;
        end

        v_re = cmd.latch_lo || cmd.rd_vy || cmd.rd_v0 || cmd.st_rd;
        priority if (cmd.latch_lo)
        begin
            v_raddr = x;
        end
        else if (cmd.rd_vy)
        begin
            v_raddr = y;
        end
        else if (cmd.st_rd)
        begin
            v_raddr = cnt_reg;
        end
        else
        begin
            v_raddr = 4'd0;
        end

        fb_re    = cmd.draw_rd || cmd.row_rd;
        fb_raddr = cmd.row_rd ? row_sel_reg : draw_row;
    end

    // Main memory
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_waddr] <= mem_wdata;
        end
        if (mem_re)
        begin
            mem_q_reg <= mem[mem_raddr];
        end
    end

    // V register file
    always_ff @(posedge clk)
    begin
        if (v_we)
        begin
            vmem[v_waddr] <= v_wdata;
        end
        if (v_re)
        begin
            vq_raw_reg <= vmem[v_raddr];
            vq_vld_reg <= v_valid_reg[v_raddr];
        end
    end

    // Frame buffer
    always_ff @(posedge clk)
    begin
        if (cmd.draw_wr)
        begin
            fbmem[draw_row] <= fb_q ^ sprite_mask;
        end
        if (fb_re)
        begin
            fb_q_raw_reg <= fbmem[fb_raddr];
            fbq_vld_reg  <= fb_valid_reg[fb_raddr];
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (push_en)
        begin
            stack_reg[sp_reg[c8ic_pkg::STK_AW-1:0]] <= pc_inc;
        end
        if (cmd.accept)
        begin
            keys_reg    <= keys;
            rnd_reg     <= random_byte;
            row_sel_reg <= row_select;
            ld_addr_reg <= load_address;
            ld_data_reg <= load_data;
        end
        if (cmd.fetch_lo)
        begin
            ins_reg[15:8] <= mem_q_reg;
        end
        if (cmd.latch_lo)
        begin
            ins_reg[7:0] <= mem_q_reg;
        end
        if (cmd.rd_vy)
        begin
            vx_reg <= vq;
        end
        if (cmd.rd_v0)
        begin
            vy_reg <= vq;
        end
        flag_reg <= flag_next;
        if (cmd.out_load)
        begin
            program_counter <= pc_reg;
            index_value     <= i_reg;
            delay_value     <= dt_reg;
            sound_on        <= st_reg != 8'd0;
            waiting_key     <= wait_reg;
            display_row     <= fb_q;
            status          <= status_reg;
        end
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pc_reg        <= c8ic_pkg::RESET_PC;
            i_reg         <= '0;
            dt_reg        <= '0;
            st_reg        <= '0;
            sp_reg        <= '0;
            v_valid_reg   <= '0;
            fb_valid_reg  <= '0;
            clr_addr_reg  <= '0;
            font_cnt_reg  <= '0;
            font_pend_reg <= 1'b0;
            font_base_reg <= '0;
            copy_base_reg <= '0;
            status_reg    <= c8ic_pkg::ST_OK;
            wait_reg      <= 1'b0;
            cnt_reg       <= '0;
        end
        else
        begin
            pc_reg     <= pc_next;
            i_reg      <= i_next;
            dt_reg     <= dt_next;
            st_reg     <= st_next;
            sp_reg     <= sp_next;
            status_reg <= status_next;
            wait_reg   <= wait_next;
            if (v_we)
            begin
                v_valid_reg[v_waddr] <= 1'b1;
            end
            if (fb_clear)
            begin
                fb_valid_reg <= '0;
            end
            else if (cmd.draw_wr)
            begin
                fb_valid_reg[draw_row] <= 1'b1;
            end
            if (cmd.clr_step)
            begin
                clr_addr_reg <= clr_addr_reg + AW'(1);
            end
            // Advance the font copy
            if (cmd.font_start)
            begin
                copy_base_reg <= font_base_reg;
                font_cnt_reg  <= '0;
            end
            else if (cmd.font_step)
            begin
                font_cnt_reg <= font_cnt_reg + c8ic_pkg::FONT_AW'(1);
            end
            // Take a font_base write and hold the copy request until it starts
            if (cfg_we && cfg_index == c8ic_pkg::REG_FONT_BASE)
            begin
                font_base_reg <= cfg_data;
                font_pend_reg <= 1'b1;
            end
            else if (cmd.font_start)
            begin
                font_pend_reg <= 1'b0;
            end
            // Loop counter
            if (cmd.exec)
            begin
                cnt_reg <= '0;
            end
            else if (cmd.draw_wr || cmd.bcd_wr || cmd.st_wr || cmd.ld_wr)
            begin
                cnt_reg <= cnt_reg + 4'd1;
            end
        end
    end

    // Report status to the sequencer
    always_comb
    begin
        sts           = '0;
        sts.ins       = ins_reg;
        sts.cnt_eq_x  = cnt_reg == x;
        sts.cnt_eq_n  = cnt_reg == n;
        sts.cnt_eq_2  = cnt_reg == 4'd2;
        sts.clr_last  = clr_addr_reg == AW'(c8ic_pkg::MEM_BYTES - 1);
        sts.font_last = font_cnt_reg == c8ic_pkg::FONT_AW'(c8ic_pkg::FONT_BYTES - 1);
        sts.font_pend = font_pend_reg;
    end

endmodule
`default_nettype wire

FILE: src/chip8_instruction_core.sv
// CHIP-8 core: sequencer plus datapath; depends on c8ic_pkg, c8ic_ctrl and c8ic_dp.
// An instruction fetches two bytes, reads Vx, Vy and V0, executes, then loops for Dxyn, Fx33,
// Fx55 and Fx65 and writes VF for 8xy4..8xyE and Dxyn; memory and V file have one read and
// one write port each. Requests run one at a time; the next is taken while the last result
// waits. Reset: a sweep zeroes memory and lays the font at 0, and a font_base write starts a
// font copy; requests wait during both.
`default_nettype none
module chip8_instruction_core (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        in_valid,
    output logic                             in_stall,
    input  wire logic [1:0]                  op,
    input  wire logic [11:0]                 load_address,
    input  wire logic [7:0]                  load_data,
    input  wire logic [15:0]                 keys,
    input  wire logic [7:0]                  random_byte,
    input  wire logic [4:0]                  row_select,
    output logic                             out_valid,
    input  wire logic                        out_stall,
    output logic [11:0]                      program_counter,
    output logic [15:0]                      index_value,
    output logic [7:0]                       delay_value,
    output logic                             sound_on,
    output logic                             waiting_key,
    output logic [63:0]                      display_row,
    output logic [1:0]                       status,
    input  wire logic                        cfg_we,
    input  wire logic [c8ic_pkg::CFG_IW-1:0] cfg_index,
    input  wire logic [c8ic_pkg::CFG_DW-1:0] cfg_data
);

    c8ic_pkg::cmd_t cmd;
    c8ic_pkg::sts_t sts;

    c8ic_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .op        (op),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .sts       (sts),
        .cmd       (cmd)
    );

    c8ic_dp u_dp (
        .clk             (clk),
        .rst_n           (rst_n),
        .cmd             (cmd),
        .sts             (sts),
        .cfg_we          (cfg_we),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .load_address    (load_address),
        .load_data       (load_data),
        .keys            (keys),
        .random_byte     (random_byte),
        .row_select      (row_select),
        .program_counter (program_counter),
        .index_value     (index_value),
        .delay_value     (delay_value),
        .sound_on        (sound_on),
        .waiting_key     (waiting_key),
        .display_row     (display_row),
        .status          (status)
    );

endmodule
`default_nettype wire

FILE: src/c8ic_checker.sv
// Port-level checks for the CHIP-8 core, attached to the top level by bind.
// Depends on c8ic_pkg and the ports of chip8_instruction_core.
`default_nettype none
module c8ic_checker (
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        in_valid,
    input wire logic        in_stall,
    input wire logic        out_valid,
    input wire logic        out_stall,
    input wire logic [11:0] program_counter,
    input wire logic        waiting_key,
    input wire logic [1:0]  status
);

    // One request at a time: busy right after an accept
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> in_stall)
        else $error("request accepted while busy");

    // A held result stays valid and keeps its program counter
    a_result_holds: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(program_counter))
        else $error("stalled result changed");

    // Status has only three codes
    a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> status <= c8ic_pkg::ST_STACK)
        else $error("bad status code");

    // A key wait is never reported with an error
    a_wait_ok: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && waiting_key |-> status == c8ic_pkg::ST_OK)
        else $error("key wait with error status");

endmodule

bind chip8_instruction_core c8ic_checker u_c8ic_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .program_counter (program_counter),
    .waiting_key     (waiting_key),
    .status          (status)
);
`default_nettype wire
